>>> rtl/core/gbi_pkg.sv
// -----------------------------------------------------------------------------
// gbi_pkg: shared constants, types and helpers of the grid bin index block
// Holds the fixed-point widths, the operation and register codes, the stage
// payload structures and the small helper functions of the pipeline.
// -----------------------------------------------------------------------------
package gbi_pkg;

   // Fixed-point format and grid limits.
   localparam int FRAC_BITS   = 16;
   localparam int MAX_CELLS   = 256;

   // Field widths.
   localparam int COORD_W     = 32;
   localparam int HALF_W      = 31;
   localparam int INV_W       = 24;
   localparam int OP_W        = 2;
   localparam int BIN_W       = 32;
   localparam int FIELD_W     = 8;
   localparam int CSR_CELLS_W = 9;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Internal widths.
   localparam int NW          = $clog2(MAX_CELLS + 1);   // effective cell count
   localparam int CELL_W      = $clog2(MAX_CELLS);       // clamped cell index
   localparam int TOTAL_W     = 2 * NW;                  // cells_y * cells_z
   localparam int DIFF_W      = COORD_W + 2;             // coord - origin +/- half
   localparam int MAG_W       = COORD_W + 1;             // magnitude of that
   localparam int PROD_W      = MAG_W + INV_W;
   localparam int Q_W         = PROD_W - 2 * FRAC_BITS;  // truncated cell magnitude
   localparam int CELL_SW     = Q_W + 1;                 // signed cell
   localparam int SPAN_SW     = CELL_SW + 1;             // signed span
   localparam int LIN_W       = CELL_SW + NW + 2;        // signed linear bin

   // Stream payload widths.
   localparam int REQ_FIELDS_W = 2 * COORD_W + 2 * HALF_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = BIN_W + 4 * FIELD_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Lanes of the per-axis cell datapath.
   localparam int NUM_LANES = 4;
   localparam int LANE_LO_Y = 0;
   localparam int LANE_HI_Y = 1;
   localparam int LANE_LO_Z = 2;
   localparam int LANE_HI_Z = 3;

   typedef enum logic [OP_W-1:0] {
      OP_RAW_BIN,
      OP_BOUNDED_BIN,
      OP_AXIS_CELLS,
      OP_WINDOW
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_Y_ORIGIN,
      CSR_Z_ORIGIN,
      CSR_Y_INV_STEP,
      CSR_Z_INV_STEP,
      CSR_CELLS_Y,
      CSR_CELLS_Z
   } csr_addr_type;

   // Stage 1: window edges relative to the grid origin.
   typedef struct packed {
      op_type                              op;
      logic [NUM_LANES-1:0][DIFF_W-1:0]    diff;
   } s1_type;

   // Stage 2: sign and magnitude of each edge.
   typedef struct packed {
      op_type                              op;
      logic [NUM_LANES-1:0]                neg;
      logic [NUM_LANES-1:0][MAG_W-1:0]     mag;
   } s2_type;

   // Stage 3: truncated product magnitude.
   typedef struct packed {
      op_type                              op;
      logic [NUM_LANES-1:0]                neg;
      logic [NUM_LANES-1:0][Q_W-1:0]       q;
   } s3_type;

   // Stage 4: signed cell per edge.
   typedef struct packed {
      op_type                              op;
      logic [NUM_LANES-1:0][CELL_SW-1:0]   lane_cell;
   } s4_type;

   // Stage 5: clamped corner and raw spans.
   typedef struct packed {
      op_type                  op;
      logic signed [CELL_SW-1:0] raw_y;
      logic signed [CELL_SW-1:0] raw_z;
      logic [CELL_W-1:0]       clamp_y;
      logic [CELL_W-1:0]       clamp_z;
      logic signed [SPAN_SW-1:0] span_y;
      logic signed [SPAN_SW-1:0] span_z;
   } s5_type;

   // Stage 6: row product and cut spans.
   typedef struct packed {
      op_type                  op;
      logic signed [LIN_W-1:0] prod_z;
      logic signed [CELL_SW-1:0] add_y;
      logic [FIELD_W-1:0]      bin_y;
      logic [FIELD_W-1:0]      bin_z;
      logic [FIELD_W-1:0]      span_y;
      logic [FIELD_W-1:0]      span_z;
   } s6_type;

   // Stage 7: full linear bin.
   typedef struct packed {
      op_type                  op;
      logic signed [LIN_W-1:0] lin;
      logic [FIELD_W-1:0]      bin_y;
      logic [FIELD_W-1:0]      bin_z;
      logic [FIELD_W-1:0]      span_y;
      logic [FIELD_W-1:0]      span_z;
   } s7_type;

   // Result item.
   typedef struct packed {
      logic                    out_of_range;
      logic [FIELD_W-1:0]      span_z;
      logic [FIELD_W-1:0]      span_y;
      logic [FIELD_W-1:0]      bin_z;
      logic [FIELD_W-1:0]      bin_y;
      logic [BIN_W-1:0]        bin;
   } rsp_type;

   // A cell count of zero counts as one; counts above the limit saturate.
   function automatic logic [NW-1:0] eff_cells(input logic [CSR_CELLS_W-1:0] raw);
      logic [NW-1:0] res;
      if (raw == '0) begin
         res = NW'(1);
      end else if (int'(raw) > MAX_CELLS) begin
         res = NW'(MAX_CELLS);
      end else begin
         res = NW'(raw);
      end
      return res;
   endfunction

   // Clamp a signed cell to [0, n-1].
   function automatic logic [CELL_W-1:0] clamp_cell(input logic signed [CELL_SW-1:0] c,
                                                    input logic [NW-1:0] n);
      logic [CELL_W-1:0] res;
      if (c < 0) begin
         res = '0;
      end else if (c >= $signed(CELL_SW'(n))) begin
         res = CELL_W'(n - NW'(1));
      end else begin
         res = CELL_W'(c);
      end
      return res;
   endfunction

endpackage

>>> rtl/core/grid_bin_index.sv
// -----------------------------------------------------------------------------
// grid_bin_index: uniform 2D grid cell index
// Maps a fixed-point point (y, z) onto a uniform grid and returns the linear
// bin, the clamped axis cells or a window's corner bin and spans.
// -----------------------------------------------------------------------------
// The block takes one point per clock while the result side does not stall and
// returns one result per point, in order. It is an eight-stage pipeline with no
// shared unit, so one item enters every cycle unless the result side stalls;
// the per-cycle work is set by the four 33x24 bit multipliers of stage three and
// the row multiplier of stage six. A stall on the result side freezes the whole
// pipeline and drops req_tready in the same cycle, so nothing is lost or
// repeated. The six grid registers are written through the csr_ port and must
// only change while no item is in flight; the grid size product used for
// bounding is re-registered from the stored cell counts in the cycle after a
// count changes. There is no clearing pass after reset.
// -----------------------------------------------------------------------------
module grid_bin_index (
   input  logic                                clock,
   input  logic                                reset,

   // Point stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: y[31:0], z[63:32], half_width_y[94:64], half_width_z[125:95], zero pad
   input  logic [gbi_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: op[1:0]
   input  logic [gbi_pkg::OP_W-1:0]            req_tuser,

   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: bin[31:0], bin_y[39:32], bin_z[47:40], span_y[55:48], span_z[63:56],
   //        out_of_range[64], zero pad
   output logic [gbi_pkg::RSP_DATA_W-1:0]      rsp_tdata,

   // Register write port.
   input  logic                                csr_we,
   input  logic [gbi_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [gbi_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NUM_STAGES = 8;

   localparam logic signed [gbi_pkg::LIN_W-1:0] BIN_MAX =
      {{(gbi_pkg::LIN_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [gbi_pkg::LIN_W-1:0] BIN_MIN =
      {{(gbi_pkg::LIN_W-31){1'b1}}, {31{1'b0}}};

   // ---------------------------------------------------------------------------
   // Grid registers. The cell counts are stored already limited to the legal
   // range, so the datapath never sees a zero or oversized count.
   // ---------------------------------------------------------------------------
   logic [gbi_pkg::COORD_W-1:0] y_origin_ff;
   logic [gbi_pkg::COORD_W-1:0] z_origin_ff;
   logic [gbi_pkg::INV_W-1:0]   y_inv_ff;
   logic [gbi_pkg::INV_W-1:0]   z_inv_ff;
   logic [gbi_pkg::NW-1:0]      cells_y_ff;
   logic [gbi_pkg::NW-1:0]      cells_z_ff;
   logic [gbi_pkg::TOTAL_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_origin_ff <= '0;
         z_origin_ff <= '0;
         y_inv_ff    <= gbi_pkg::INV_W'(1 << gbi_pkg::FRAC_BITS);
         z_inv_ff    <= gbi_pkg::INV_W'(1 << gbi_pkg::FRAC_BITS);
         cells_y_ff  <= gbi_pkg::NW'(1);
         cells_z_ff  <= gbi_pkg::NW'(1);
         total_ff    <= gbi_pkg::TOTAL_W'(1);
      end else begin
         // The grid size follows the counts in the next cycle.
         total_ff <= gbi_pkg::TOTAL_W'(cells_y_ff) * gbi_pkg::TOTAL_W'(cells_z_ff);
         if (csr_we) begin
            unique case (csr_addr)
               gbi_pkg::CSR_Y_ORIGIN:   y_origin_ff <= csr_wdata;
               gbi_pkg::CSR_Z_ORIGIN:   z_origin_ff <= csr_wdata;
               gbi_pkg::CSR_Y_INV_STEP: y_inv_ff    <= gbi_pkg::INV_W'(csr_wdata);
               gbi_pkg::CSR_Z_INV_STEP: z_inv_ff    <= gbi_pkg::INV_W'(csr_wdata);
               gbi_pkg::CSR_CELLS_Y:
                  cells_y_ff <= gbi_pkg::eff_cells(gbi_pkg::CSR_CELLS_W'(csr_wdata));
               gbi_pkg::CSR_CELLS_Z:
                  cells_z_ff <= gbi_pkg::eff_cells(gbi_pkg::CSR_CELLS_W'(csr_wdata));
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline control. All stages move together whenever the output register
   // is empty or its result is being taken; valid bits travel with the data.
   // ---------------------------------------------------------------------------
   logic                  advance;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;

   assign advance    = !valid_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign valid_in   = {valid_ff[NUM_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: subtract the origin and move by the half-width. The lower edge
   // is the point itself unless a window is requested.
   // ---------------------------------------------------------------------------
   gbi_pkg::s1_type s1_in, s1_ff;

   always_comb begin
      logic [gbi_pkg::COORD_W-1:0] pt_y;
      logic [gbi_pkg::COORD_W-1:0] pt_z;
      logic [gbi_pkg::HALF_W-1:0]  hw_y;
      logic [gbi_pkg::HALF_W-1:0]  hw_z;
      logic [gbi_pkg::DIFF_W-1:0]  dy;
      logic [gbi_pkg::DIFF_W-1:0]  dz;
      logic [gbi_pkg::DIFF_W-1:0]  hy;
      logic [gbi_pkg::DIFF_W-1:0]  hz;
      logic                        win;
      pt_y = req_tdata[gbi_pkg::COORD_W-1:0];
      pt_z = req_tdata[2*gbi_pkg::COORD_W-1:gbi_pkg::COORD_W];
      hw_y = req_tdata[2*gbi_pkg::COORD_W+gbi_pkg::HALF_W-1:2*gbi_pkg::COORD_W];
      hw_z = req_tdata[gbi_pkg::REQ_FIELDS_W-1:2*gbi_pkg::COORD_W+gbi_pkg::HALF_W];
      win  = (gbi_pkg::op_type'(req_tuser) == gbi_pkg::OP_WINDOW);
      dy   = gbi_pkg::DIFF_W'($signed(pt_y)) - gbi_pkg::DIFF_W'($signed(y_origin_ff));
      dz   = gbi_pkg::DIFF_W'($signed(pt_z)) - gbi_pkg::DIFF_W'($signed(z_origin_ff));
      hy   = gbi_pkg::DIFF_W'(hw_y);
      hz   = gbi_pkg::DIFF_W'(hw_z);
      s1_in.op                       = gbi_pkg::op_type'(req_tuser);
      s1_in.diff[gbi_pkg::LANE_LO_Y] = win ? (dy - hy) : dy;
      s1_in.diff[gbi_pkg::LANE_HI_Y] = dy + hy;
      s1_in.diff[gbi_pkg::LANE_LO_Z] = win ? (dz - hz) : dz;
      s1_in.diff[gbi_pkg::LANE_HI_Z] = dz + hz;
   end

   // ---------------------------------------------------------------------------
   // Stage 2: split each edge into sign and magnitude, so the product below
   // truncates toward zero.
   // ---------------------------------------------------------------------------
   gbi_pkg::s2_type s2_in, s2_ff;

   always_comb begin
      s2_in.op = s1_ff.op;
      for (int i = 0; i < gbi_pkg::NUM_LANES; i++) begin
         s2_in.neg[i] = s1_ff.diff[i][gbi_pkg::DIFF_W-1];
         s2_in.mag[i] = s2_in.neg[i] ? gbi_pkg::MAG_W'(-s1_ff.diff[i])
                                     : gbi_pkg::MAG_W'(s1_ff.diff[i]);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: scale by the inverse cell size and drop the fraction bits.
   // ---------------------------------------------------------------------------
   gbi_pkg::s3_type s3_in, s3_ff;
   logic [gbi_pkg::PROD_W-1:0] lane_prod [gbi_pkg::NUM_LANES];

   always_comb begin
      s3_in.op  = s2_ff.op;
      s3_in.neg = s2_ff.neg;
      for (int i = 0; i < gbi_pkg::NUM_LANES; i++) begin
         lane_prod[i] = gbi_pkg::PROD_W'(s2_ff.mag[i]) *
                        gbi_pkg::PROD_W'((i < gbi_pkg::LANE_LO_Z) ? y_inv_ff : z_inv_ff);
         s3_in.q[i]   = lane_prod[i][gbi_pkg::PROD_W-1:2*gbi_pkg::FRAC_BITS];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: restore the sign of each cell.
   // ---------------------------------------------------------------------------
   gbi_pkg::s4_type s4_in, s4_ff;

   always_comb begin
      s4_in.op = s3_ff.op;
      for (int i = 0; i < gbi_pkg::NUM_LANES; i++) begin
         s4_in.lane_cell[i] = s3_ff.neg[i] ? -gbi_pkg::CELL_SW'(s3_ff.q[i])
                                           :  gbi_pkg::CELL_SW'(s3_ff.q[i]);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: clamp the lower corner into the grid and form the raw spans,
   // which are measured from the unclamped lower edge.
   // ---------------------------------------------------------------------------
   gbi_pkg::s5_type s5_in, s5_ff;

   always_comb begin
      logic signed [gbi_pkg::CELL_SW-1:0] lo_y;
      logic signed [gbi_pkg::CELL_SW-1:0] hi_y;
      logic signed [gbi_pkg::CELL_SW-1:0] lo_z;
      logic signed [gbi_pkg::CELL_SW-1:0] hi_z;
      lo_y = $signed(s4_ff.lane_cell[gbi_pkg::LANE_LO_Y]);
      hi_y = $signed(s4_ff.lane_cell[gbi_pkg::LANE_HI_Y]);
      lo_z = $signed(s4_ff.lane_cell[gbi_pkg::LANE_LO_Z]);
      hi_z = $signed(s4_ff.lane_cell[gbi_pkg::LANE_HI_Z]);
      s5_in.op      = s4_ff.op;
      s5_in.raw_y   = lo_y;
      s5_in.raw_z   = lo_z;
      s5_in.clamp_y = gbi_pkg::clamp_cell(lo_y, cells_y_ff);
      s5_in.clamp_z = gbi_pkg::clamp_cell(lo_z, cells_z_ff);
      s5_in.span_y  = gbi_pkg::SPAN_SW'(hi_y) - gbi_pkg::SPAN_SW'(lo_y);
      s5_in.span_z  = gbi_pkg::SPAN_SW'(hi_z) - gbi_pkg::SPAN_SW'(lo_z);
   end

   // ---------------------------------------------------------------------------
   // Stage 6: multiply the z cell by the row length. Point ops use the raw
   // cells, the axis and window ops the clamped ones. Spans that would run
   // past the grid edge are cut back to the last cell.
   // ---------------------------------------------------------------------------
   gbi_pkg::s6_type s6_in, s6_ff;

   always_comb begin
      logic                                use_clamp;
      logic signed [gbi_pkg::CELL_SW-1:0]  sel_z;
      logic signed [gbi_pkg::SPAN_SW:0]    reach_y;
      logic signed [gbi_pkg::SPAN_SW:0]    reach_z;
      use_clamp = (s5_ff.op == gbi_pkg::OP_AXIS_CELLS) || (s5_ff.op == gbi_pkg::OP_WINDOW);
      sel_z     = use_clamp ? $signed(gbi_pkg::CELL_SW'(s5_ff.clamp_z)) : s5_ff.raw_z;
      s6_in.op     = s5_ff.op;
      s6_in.prod_z = gbi_pkg::LIN_W'(sel_z) *
                     gbi_pkg::LIN_W'($signed({1'b0, cells_y_ff}));
      s6_in.add_y  = use_clamp ? $signed(gbi_pkg::CELL_SW'(s5_ff.clamp_y)) : s5_ff.raw_y;
      s6_in.bin_y  = gbi_pkg::FIELD_W'(s5_ff.clamp_y);
      s6_in.bin_z  = gbi_pkg::FIELD_W'(s5_ff.clamp_z);

      reach_y = $signed((gbi_pkg::SPAN_SW+1)'(s5_ff.clamp_y)) +
                (gbi_pkg::SPAN_SW+1)'(s5_ff.span_y);
      reach_z = $signed((gbi_pkg::SPAN_SW+1)'(s5_ff.clamp_z)) +
                (gbi_pkg::SPAN_SW+1)'(s5_ff.span_z);
      if (reach_y >= $signed((gbi_pkg::SPAN_SW+1)'(cells_y_ff))) begin
         s6_in.span_y = gbi_pkg::FIELD_W'(cells_y_ff - gbi_pkg::NW'(1) -
                                          gbi_pkg::NW'(s5_ff.clamp_y));
      end else begin
         s6_in.span_y = gbi_pkg::FIELD_W'(s5_ff.span_y);
      end
      if (reach_z >= $signed((gbi_pkg::SPAN_SW+1)'(cells_z_ff))) begin
         s6_in.span_z = gbi_pkg::FIELD_W'(cells_z_ff - gbi_pkg::NW'(1) -
                                          gbi_pkg::NW'(s5_ff.clamp_z));
      end else begin
         s6_in.span_z = gbi_pkg::FIELD_W'(s5_ff.span_z);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: add the y cell to get the linear bin.
   // ---------------------------------------------------------------------------
   gbi_pkg::s7_type s7_in, s7_ff;

   always_comb begin
      s7_in.op     = s6_ff.op;
      s7_in.lin    = s6_ff.prod_z + gbi_pkg::LIN_W'(s6_ff.add_y);
      s7_in.bin_y  = s6_ff.bin_y;
      s7_in.bin_z  = s6_ff.bin_z;
      s7_in.span_y = s6_ff.span_y;
      s7_in.span_z = s6_ff.span_z;
   end

   // ---------------------------------------------------------------------------
   // Stage 8: range check, saturation or bounding per op, and the output
   // register. Fields an op does not produce are zero.
   // ---------------------------------------------------------------------------
   gbi_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      logic signed [gbi_pkg::LIN_W-1:0] total;
      logic                             below;
      logic                             above;
      total = $signed(gbi_pkg::LIN_W'(total_ff));
      below = (s7_ff.lin < 0);
      above = (s7_ff.lin >= total);
      rsp_in = '0;
      unique case (s7_ff.op)
         gbi_pkg::OP_RAW_BIN: begin
            rsp_in.out_of_range = below || above;
            if (s7_ff.lin > BIN_MAX) begin
               rsp_in.bin = gbi_pkg::BIN_W'(BIN_MAX);
            end else if (s7_ff.lin < BIN_MIN) begin
               rsp_in.bin = gbi_pkg::BIN_W'(BIN_MIN);
            end else begin
               rsp_in.bin = gbi_pkg::BIN_W'(s7_ff.lin);
            end
         end
         gbi_pkg::OP_BOUNDED_BIN: begin
            if (above) begin
               rsp_in.bin = gbi_pkg::BIN_W'(total - gbi_pkg::LIN_W'(1));
            end else if (below) begin
               rsp_in.bin = '0;
            end else begin
               rsp_in.bin = gbi_pkg::BIN_W'(s7_ff.lin);
            end
         end
         gbi_pkg::OP_AXIS_CELLS: begin
            rsp_in.bin_y = s7_ff.bin_y;
            rsp_in.bin_z = s7_ff.bin_z;
         end
         gbi_pkg::OP_WINDOW: begin
            rsp_in.bin    = gbi_pkg::BIN_W'(s7_ff.lin);
            rsp_in.bin_y  = s7_ff.bin_y;
            rsp_in.bin_z  = s7_ff.bin_z;
            rsp_in.span_y = s7_ff.span_y;
            rsp_in.span_z = s7_ff.span_z;
         end
         default: begin
         end
      endcase
   end

   // Stage payload registers need no reset; the valid bits qualify them.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata = gbi_pkg::RSP_DATA_W'(rsp_ff);

endmodule
